@@ rtl/core/efr_pkg.sv @@
// efr_pkg: shared types and constants for the escaped frame receiver
// used by efr_ctrl, efr_datapath and escaped_frame_receiver
`timescale 1ns / 1ps

package efr_pkg;

    // framing and escape codes
    localparam logic [7:0] FRAME_START = 8'hC0;
    localparam logic [7:0] ESC_MARK    = 8'hDB;
    localparam logic [7:0] ESC_START   = 8'hDC;
    localparam logic [7:0] ESC_ESC     = 8'hDD;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 7;
    localparam int LEN_W    = 6;
    localparam int MAXLEN_W = 7;
    localparam int TDATA_W  = 32;

    // one above the largest length that fits in the length field
    localparam int LEN_LIMIT = 64;

    // configuration register indexes
    localparam logic CFG_VERSION = 1'b0;
    localparam logic CFG_MAXLEN  = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0]   VERSION_RST = 8'd1;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RST  = 7'd37;

    localparam int BUFFER_DEPTH_DEF = 64;

    // controller to datapath commands
    typedef struct packed {
        logic take;        // byte transfer accepted, update escape flag
        logic hold_cmd;    // latch command byte
        logic hold_len;    // latch length byte, rewind write position
        logic write_data;  // store payload byte
        logic start_drain; // rewind read index
        logic fetch;       // read buffer into the output register
        logic advance;     // step read index
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_start;  // raw frame start byte
        logic is_esc;    // raw escape mark byte
        logic ver_ok;
        logic cmd_ok;
        logic len_ok;
        logic len_zero;
        logic data_done; // this payload byte completes the packet
        logic out_last;  // output register holds final result
    } dp_status_t;

endpackage

@@ rtl/core/efr_ctrl.sv @@
// efr_ctrl: frame phase state machine and output sequencing
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  efr_pkg::dp_status_t status,
    output efr_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_VERSION = 7'b0000010,
        ST_COMMAND = 7'b0000100,
        ST_LENGTH  = 7'b0001000,
        ST_DATA    = 7'b0010000,
        ST_FETCH   = 7'b0100000,
        ST_SEND    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    assign s_tready = (state_reg != ST_FETCH) && (state_reg != ST_SEND);
    assign m_tvalid = (state_reg == ST_SEND);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.take   = in_fire;
        if (in_fire)
        begin
            priority if (status.is_start)
            begin
                state_next = ST_VERSION;
            end
            else if (status.is_esc)
            begin
                state_next = state_reg;
            end
            else
            begin
                unique case (state_reg)
                    ST_VERSION:
                    begin
                        state_next = status.ver_ok ? ST_COMMAND : ST_IDLE;
                    end
                    ST_COMMAND:
                    begin
                        cmd.hold_cmd = status.cmd_ok;
                        state_next   = status.cmd_ok ? ST_LENGTH : ST_IDLE;
                    end
                    ST_LENGTH:
                    begin
                        if (status.len_ok)
                        begin
                            cmd.hold_len = 1'b1;
                            if (status.len_zero)
                            begin
                                cmd.start_drain = 1'b1;
                                state_next      = ST_FETCH;
                            end
                            else
                            begin
                                state_next = ST_DATA;
                            end
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    ST_DATA:
                    begin
                        cmd.write_data = 1'b1;
                        if (status.data_done)
                        begin
                            cmd.start_drain = 1'b1;
                            state_next      = ST_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
        else
        begin
            unique case (state_reg)
                ST_FETCH:
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_SEND;
                end
                ST_SEND:
                begin
                    if (out_fire)
                    begin
                        if (status.out_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = ST_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/efr_datapath.sv @@
// efr_datapath: unescape, field checks, payload buffer and output register
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_datapath
#(
    parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]        cfg_data,
    input  logic [efr_pkg::BYTE_W-1:0]        rx_byte,
    input  efr_pkg::ctl_cmd_t                 cmd,
    output efr_pkg::dp_status_t               status,
    output logic [efr_pkg::CMD_W-1:0]         command_code,
    output logic [efr_pkg::LEN_W-1:0]         payload_length,
    output logic [efr_pkg::LEN_W-1:0]         byte_index,
    output logic [efr_pkg::BYTE_W-1:0]        payload_byte,
    output logic                              empty_packet,
    output logic                              last
);

    // only lengths below both limits are ever stored
    localparam int STORE_DEPTH = (BUFFER_DEPTH < efr_pkg::LEN_LIMIT) ?
                                 BUFFER_DEPTH : efr_pkg::LEN_LIMIT;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam logic [efr_pkg::BYTE_W:0] DEPTH_CMP = (efr_pkg::BYTE_W + 1)'(BUFFER_DEPTH);
    localparam logic [efr_pkg::BYTE_W:0] LIMIT_CMP =
        (efr_pkg::BYTE_W + 1)'(efr_pkg::LEN_LIMIT);

    logic [efr_pkg::BYTE_W-1:0]   version_reg;
    logic [efr_pkg::MAXLEN_W-1:0] max_len_reg;
    logic                         esc_reg;
    logic [efr_pkg::CMD_W-1:0]    held_cmd_reg;
    logic [efr_pkg::LEN_W-1:0]    held_len_reg;
    logic [efr_pkg::LEN_W-1:0]    wr_pos_reg;
    logic [efr_pkg::LEN_W-1:0]    rd_idx_reg;
    logic [efr_pkg::BYTE_W-1:0]   payload_mem [STORE_DEPTH];

    logic [efr_pkg::CMD_W-1:0]    out_cmd_reg;
    logic [efr_pkg::LEN_W-1:0]    out_len_reg;
    logic [efr_pkg::LEN_W-1:0]    out_idx_reg;
    logic [efr_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                         out_empty_reg;
    logic                         out_last_reg;

    logic [efr_pkg::BYTE_W-1:0]   data_byte;
    logic [efr_pkg::LEN_W:0]      wr_pos_inc;
    logic [efr_pkg::LEN_W:0]      rd_idx_inc;
    logic                         held_empty;

    // unescaped byte
    always_comb
    begin
        data_byte = rx_byte;
        if (esc_reg && (rx_byte == efr_pkg::ESC_START))
        begin
            data_byte = efr_pkg::FRAME_START;
        end
        else if (esc_reg && (rx_byte == efr_pkg::ESC_ESC))
        begin
            data_byte = efr_pkg::ESC_MARK;
        end
    end

    assign wr_pos_inc = {1'b0, wr_pos_reg} + 1'b1;
    assign rd_idx_inc = {1'b0, rd_idx_reg} + 1'b1;
    assign held_empty = (held_len_reg == '0);

    assign status.is_start  = (rx_byte == efr_pkg::FRAME_START);
    assign status.is_esc    = (rx_byte == efr_pkg::ESC_MARK);
    assign status.ver_ok    = (data_byte == version_reg);
    assign status.cmd_ok    = !data_byte[efr_pkg::BYTE_W-1];
    assign status.len_ok    = (data_byte < {1'b0, max_len_reg})
                              && ({1'b0, data_byte} < DEPTH_CMP)
                              && ({1'b0, data_byte} < LIMIT_CMP);
    assign status.len_zero  = (data_byte == '0);
    // a wrap of the write position also ends the packet
    assign status.data_done = (wr_pos_inc >= {1'b0, held_len_reg});
    assign status.out_last  = out_last_reg;

    // configuration and escape flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= efr_pkg::VERSION_RST;
            max_len_reg <= efr_pkg::MAXLEN_RST;
            esc_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    efr_pkg::CFG_VERSION: version_reg <= cfg_data;
                    efr_pkg::CFG_MAXLEN:  max_len_reg <= cfg_data[efr_pkg::MAXLEN_W-1:0];
                    default:              version_reg <= version_reg;
                endcase
            end
            if (cmd.take)
            begin
                if (status.is_start)
                begin
                    esc_reg <= 1'b0;
                end
                else if (status.is_esc)
                begin
                    esc_reg <= 1'b1;
                end
                else if (esc_reg && ((rx_byte == efr_pkg::ESC_START)
                                     || (rx_byte == efr_pkg::ESC_ESC)))
                begin
                    esc_reg <= 1'b0;
                end
            end
        end
    end

    // packet header and buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cmd_reg <= '0;
            held_len_reg <= '0;
            wr_pos_reg   <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.hold_cmd)
            begin
                held_cmd_reg <= data_byte[efr_pkg::CMD_W-1:0];
            end
            if (cmd.hold_len)
            begin
                held_len_reg <= data_byte[efr_pkg::LEN_W-1:0];
                wr_pos_reg   <= '0;
            end
            else if (cmd.write_data)
            begin
                wr_pos_reg <= wr_pos_inc[efr_pkg::LEN_W-1:0];
            end
            if (cmd.start_drain)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                rd_idx_reg <= rd_idx_inc[efr_pkg::LEN_W-1:0];
            end
        end
    end

    // payload buffer write
    always_ff @(posedge clk)
    begin
        if (cmd.write_data)
        begin
            payload_mem[wr_pos_reg[ADDR_W-1:0]] <= data_byte;
        end
    end

    // output register, buffer read lands here
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            out_cmd_reg   <= held_cmd_reg;
            out_len_reg   <= held_len_reg;
            out_idx_reg   <= rd_idx_reg;
            out_byte_reg  <= held_empty ? '0 : payload_mem[rd_idx_reg[ADDR_W-1:0]];
            out_empty_reg <= held_empty;
            out_last_reg  <= held_empty || (rd_idx_inc == {1'b0, held_len_reg});
        end
    end

    assign command_code   = out_cmd_reg;
    assign payload_length = out_len_reg;
    assign byte_index     = out_idx_reg;
    assign payload_byte   = out_byte_reg;
    assign empty_packet   = out_empty_reg;
    assign last           = out_last_reg;

endmodule

@@ rtl/core/escaped_frame_receiver.sv @@
// escaped_frame_receiver: top level of the byte-stuffed frame receiver
// depends on efr_pkg, efr_ctrl and efr_datapath
`timescale 1ns / 1ps

// Receives a byte-stuffed serial stream one byte per input transfer and
// emits each valid packet as one output transfer per payload byte. 0xC0
// starts a frame; 0xDB escapes the next byte (0xDC -> 0xC0, 0xDD -> 0xDB,
// any other byte passes and leaves the escape pending). A frame carries a
// version byte that must equal protocol_version, a command byte with bit 7
// clear, a length below max_length (and below the buffer depth and 64),
// then the payload. A zero-length packet gives one transfer marked empty on
// tuser. Any violation drops the frame silently until the next 0xC0.
// Timing: header and payload bytes are taken one per cycle. When a packet
// completes the input stalls while the buffer drains: each result takes a
// buffer read into the output register, then the output transfer, which
// waits while the sink holds tready low; the input stays closed until the
// last result of the packet is taken. The buffer is one single-port memory
// of min(BUFFER_DEPTH, 64) bytes; it needs no clearing after reset since
// only entries of the current frame are read. Configuration writes are
// taken in any cycle but must only be issued while no frame is in
// progress.

module escaped_frame_receiver
#(
    parameter int BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port, index 0 protocol_version, 1 max_length
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]   cfg_data,
    // receive byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [efr_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    // packet output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [6:0] command_code, [12:7] payload_length, [18:13] byte_index,
    // [26:19] payload_byte, [31:27] zero
    output logic [efr_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser,   // [0] empty_packet
    output logic                         m_tlast    // last result of packet
);

    localparam int PACK_W = efr_pkg::CMD_W + 2 * efr_pkg::LEN_W + efr_pkg::BYTE_W;

    efr_pkg::ctl_cmd_t   cmd;
    efr_pkg::dp_status_t status;

    logic [efr_pkg::CMD_W-1:0]  command_code;
    logic [efr_pkg::LEN_W-1:0]  payload_length;
    logic [efr_pkg::LEN_W-1:0]  byte_index;
    logic [efr_pkg::BYTE_W-1:0] payload_byte;
    logic                       empty_packet;
    logic                       last;

    // frame phase sequencing and handshakes
    efr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // unescape, checks, payload memory and output register
    efr_datapath
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .command_code   (command_code),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .empty_packet   (empty_packet),
        .last           (last)
    );

    // pack result fields, lowest field first, zero fill to 32 bits
    assign m_tdata = {{(efr_pkg::TDATA_W - PACK_W){1'b0}},
                      payload_byte, byte_index, payload_length, command_code};
    assign m_tuser = empty_packet;
    assign m_tlast = last;

endmodule

@@ rtl/core/efr_checker.sv @@
// efr_checker: port-level assertions for the escaped frame receiver
// depends on escaped_frame_receiver ports, bound to the top level
`timescale 1ns / 1ps

module efr_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // input is closed while a packet is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    // more results of the same packet follow before any new byte is taken
    a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
        else $error("input reopened mid packet");

    // empty packet is a single result with zero byte index and payload byte
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[26:13] == 14'd0)))
        else $error("malformed empty packet result");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind escaped_frame_receiver efr_port_checker u_efr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
